@@ hdl/assert_macros.svh @@
// Assertion helpers shared by checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ hdl/cpnss_pkg.sv @@
package cpnss_pkg;

	localparam int WORD_W  = 32;
	localparam int COUNT_W = 16;
	localparam int PLEN_W  = 15;
	localparam int CFG_IDX_W = 1;

	localparam int TYPE_SHIFT  = 30;
	localparam int COUNT_SHIFT = 16;
	localparam logic [13:0] COUNT_MASK = 14'h3fff;

	localparam logic [1:0] TYPE_BAD  = 2'd1;
	localparam logic [1:0] TYPE_FILL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MARKER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd1;

	localparam logic [WORD_W-1:0]  MARKER_RESET = 32'hC000_1000;
	localparam logic [COUNT_W-1:0] LIMIT_RESET  = 16'd16;

	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	localparam logic KIND_SITE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_TYPE = 2'd1,
		ST_OVERRUN  = 2'd2,
		ST_TOO_MANY = 2'd3
	} status_t;

	typedef struct packed {
		logic                kind;
		logic [WORD_W-1:0]   site_index;
		logic [WORD_W-1:0]   site_payload;
		logic [COUNT_W-1:0]  site_count;
		status_t             status;
		logic                last_of_run;
	} result_t;

	typedef struct packed {
		logic en0;
		logic en1;
	} push_t;

endpackage

@@ hdl/cpnss_rq.sv @@
module cpnss_rq (
	input  logic                clk,
	input  logic                arst_n,
	input  cpnss_pkg::push_t    push,
	input  cpnss_pkg::result_t  d0,
	input  cpnss_pkg::result_t  d1,
	output logic                room2,
	output logic                out_valid,
	input  logic                out_ready,
	output cpnss_pkg::result_t  q
);

	cpnss_pkg::result_t mem_q [cpnss_pkg::RQ_DEPTH];
	logic [cpnss_pkg::RQ_AW-1:0] wr_q, rd_q, wr1;
	logic [cpnss_pkg::RQ_AW:0]   cnt_q, cnt_n;
	logic pop;

	assign out_valid = (cnt_q != '0);
	assign q         = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room2     = (cnt_q <= (cpnss_pkg::RQ_AW+1)'(cpnss_pkg::RQ_DEPTH - 2));
	assign wr1       = wr_q + (cpnss_pkg::RQ_AW)'(1);
	assign cnt_n     = cnt_q + (cpnss_pkg::RQ_AW+1)'(push.en0) + (cpnss_pkg::RQ_AW+1)'(push.en1)
		- (cpnss_pkg::RQ_AW+1)'(pop);

	always_ff @(posedge clk) begin
		if (push.en0) begin
			mem_q[wr_q] <= d0;
		end
		if (push.en1) begin
			mem_q[wr1] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + (cpnss_pkg::RQ_AW)'(push.en0) + (cpnss_pkg::RQ_AW)'(push.en1);
			rd_q  <= rd_q + (cpnss_pkg::RQ_AW)'(pop);
			cnt_q <= cnt_n;
		end
	end

endmodule

@@ hdl/command_packet_nop_site_scanner_top.sv @@
// Command packet site scanner. Takes one command buffer word per request and
// frames packets by their headers; each marker header yields a site result
// when the following word arrives, and the flagged last word yields an end
// result with the site count and the first error. One word is taken every
// cycle while in_ready is high: a word is held in the input register, where
// the header decode and counter update are done, then its results enter a
// four-entry result queue. A last word that follows a marker header gives
// two results, drained one per cycle while out_ready is high. in_ready drops
// while the input register holds a word and the queue has fewer than two
// free entries.
module command_packet_nop_site_scanner_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [cpnss_pkg::WORD_W-1:0]         word,
	input  logic                                 is_last,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 kind,
	output logic [cpnss_pkg::WORD_W-1:0]         site_index,
	output logic [cpnss_pkg::WORD_W-1:0]         site_payload,
	output logic [cpnss_pkg::COUNT_W-1:0]        site_count,
	output logic [1:0]                           status,
	output logic                                 last_of_run,
	input  logic                                 cfg_we,
	input  logic [cpnss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cpnss_pkg::WORD_W-1:0]         cfg_data
);

	logic                           valid_s1;
	logic [cpnss_pkg::WORD_W-1:0]   word_s1;
	logic                           last_s1;

	logic [cpnss_pkg::WORD_W-1:0]   marker_q;
	logic [cpnss_pkg::COUNT_W-1:0]  limit_q;

	logic [cpnss_pkg::WORD_W-1:0]   pos_q, pos_n;
	logic [cpnss_pkg::PLEN_W-1:0]   pl_q, pl_n, plen;
	logic                           cap_q, cap_n;
	logic [cpnss_pkg::COUNT_W-1:0]  sites_q, sites_n;
	cpnss_pkg::status_t             err_q, err_n;

	logic [1:0]                     ptype;
	logic                           room2, fire;
	cpnss_pkg::push_t               push;
	cpnss_pkg::result_t             site_res, end_res, d0, res;

	assign in_ready = !valid_s1 || room2;
	assign fire     = valid_s1 && room2;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= word;
			last_s1 <= is_last;
		end
	end

	// header decode and scan state update
	assign ptype = word_s1[cpnss_pkg::TYPE_SHIFT +: 2];
	assign plen  = (ptype == cpnss_pkg::TYPE_FILL) ? '0
		: {1'b0, word_s1[cpnss_pkg::COUNT_SHIFT +: 14] & cpnss_pkg::COUNT_MASK}
			+ (cpnss_pkg::PLEN_W)'(1);

	always_comb begin
		err_n   = err_q;
		pl_n    = pl_q;
		cap_n   = 1'b0;
		sites_n = sites_q;
		if (err_q == cpnss_pkg::ST_OK) begin
			if (pl_q != '0) begin
				pl_n = pl_q - (cpnss_pkg::PLEN_W)'(1);
				if (last_s1 && pl_n != '0) begin
					err_n = cpnss_pkg::ST_OVERRUN;
				end
			end else if (ptype == cpnss_pkg::TYPE_BAD) begin
				err_n = cpnss_pkg::ST_BAD_TYPE;
			end else begin
				if (last_s1 && plen != '0) begin
					err_n = cpnss_pkg::ST_OVERRUN;
				end else if (word_s1 == marker_q) begin
					if (sites_q >= limit_q) begin
						err_n = cpnss_pkg::ST_TOO_MANY;
					end else if (last_s1) begin
						err_n = cpnss_pkg::ST_OVERRUN;
					end else begin
						sites_n = sites_q + (cpnss_pkg::COUNT_W)'(1);
						cap_n   = 1'b1;
					end
				end
				if (err_n == cpnss_pkg::ST_OK) begin
					pl_n = plen;
				end
			end
			if (err_n != cpnss_pkg::ST_OK) begin
				cap_n = 1'b0;
				pl_n  = '0;
			end
		end
		pos_n = pos_q + (cpnss_pkg::WORD_W)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= '0;
			pl_q     <= '0;
			cap_q    <= 1'b0;
			sites_q  <= '0;
			err_q    <= cpnss_pkg::ST_OK;
			marker_q <= cpnss_pkg::MARKER_RESET;
			limit_q  <= cpnss_pkg::LIMIT_RESET;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire) begin
				if (last_s1) begin
					pos_q   <= '0;
					pl_q    <= '0;
					cap_q   <= 1'b0;
					sites_q <= '0;
					err_q   <= cpnss_pkg::ST_OK;
				end else begin
					pos_q   <= pos_n;
					pl_q    <= pl_n;
					cap_q   <= cap_n;
					sites_q <= sites_n;
					err_q   <= err_n;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					cpnss_pkg::CFG_MARKER: begin
						marker_q <= cfg_data;
					end
					cpnss_pkg::CFG_LIMIT: begin
						limit_q <= cfg_data[cpnss_pkg::COUNT_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result forming
	always_comb begin
		site_res              = '0;
		site_res.kind         = cpnss_pkg::KIND_SITE;
		site_res.site_index   = pos_q;
		site_res.site_payload = word_s1;
		site_res.status       = cpnss_pkg::ST_OK;
		site_res.last_of_run  = !last_s1;

		end_res              = '0;
		end_res.kind         = cpnss_pkg::KIND_END;
		end_res.site_count   = sites_n;
		end_res.status       = err_n;
		end_res.last_of_run  = 1'b1;

		d0       = cap_q ? site_res : end_res;
		push.en0 = fire && (cap_q || last_s1);
		push.en1 = fire && cap_q && last_s1;
	end

	cpnss_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.d0        (d0),
		.d1        (end_res),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.q         (res)
	);

	assign kind         = res.kind;
	assign site_index   = res.site_index;
	assign site_payload = res.site_payload;
	assign site_count   = res.site_count;
	assign status       = res.status;
	assign last_of_run  = res.last_of_run;

endmodule

@@ hdl/cpnss_chk.sv @@
`include "assert_macros.svh"

module cpnss_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic [cpnss_pkg::WORD_W-1:0]         word,
	input logic                                 is_last,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic                                 kind,
	input logic [cpnss_pkg::WORD_W-1:0]         site_index,
	input logic [cpnss_pkg::WORD_W-1:0]         site_payload,
	input logic [cpnss_pkg::COUNT_W-1:0]        site_count,
	input logic [1:0]                           status,
	input logic                                 last_of_run,
	input logic                                 cfg_we,
	input logic [cpnss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input logic [cpnss_pkg::WORD_W-1:0]         cfg_data
);

	// stalled request keeps its payload
	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(kind) && $stable(site_index) && $stable(site_payload))

	// site results carry no summary
	`ASSERT_IMP(a_site_clean, clk, arst_n, out_valid && kind == cpnss_pkg::KIND_SITE,
		site_count == '0 && status == cpnss_pkg::ST_OK)

	// end results close the run and carry no site
	`ASSERT_IMP(a_end_clean, clk, arst_n, out_valid && kind == cpnss_pkg::KIND_END,
		last_of_run && site_index == '0 && site_payload == '0)

	// a site that is not last of its run is followed at once by the end result
	`ASSERT_NXT(a_site_then_end, clk, arst_n,
		out_valid && out_ready && kind == cpnss_pkg::KIND_SITE && !last_of_run,
		out_valid && kind == cpnss_pkg::KIND_END)

endmodule

bind command_packet_nop_site_scanner_top cpnss_chk u_chk (.*);
